[sv/pcle_pkg.sv]
`default_nettype none
package pcle_pkg;

  localparam int PHASE_FRAC_BITS = 16;
  localparam int PHASE_BITS      = 10 + PHASE_FRAC_BITS;
  localparam int RATE_W          = 17;
  // divider sized for the wider of the two divisions: (rate << frac) / (tone * 8)
  localparam int NUM_W           = RATE_W + PHASE_FRAC_BITS;
  localparam int DEN_W           = 21;
  localparam int TONE_W          = 18;
  localparam int CNT_W           = $clog2(NUM_W);
  localparam int TONE_NUM        = 131072;
  localparam int FREQ_SPAN       = 2048;
  localparam int LEN_FULL        = 64;

  localparam logic [RATE_W-1:0] RATE_RESET = 17'd44100;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  localparam logic [2:0] REG_LEN_DUTY = 3'd0;
  localparam logic [2:0] REG_ENVELOPE = 3'd1;
  localparam logic [2:0] REG_FREQ_LO  = 3'd2;
  localparam logic [2:0] REG_FREQ_HI  = 3'd3;
  localparam logic [2:0] REG_MASTER   = 3'd4;

  localparam logic [7:0] RB_FREQ_LO = 8'hFF;
  localparam logic [7:0] RB_TRIGGER = 8'hBF;
  localparam logic [7:0] RB_UNUSED  = 8'hFF;

  typedef enum logic {
    DIV_TONE,
    DIV_STEP
  } div_sel_t;

  typedef struct packed {
    logic     latch;
    logic     div_start;
    div_sel_t div_sel;
    logic     commit;
  } pcle_cmd_t;

  typedef struct packed {
    logic sample_go;
    logic div_done;
  } pcle_status_t;

  // first high step of each duty pattern
  function automatic logic [2:0] duty_first_high(input logic [1:0] sel);
    logic [2:0] r;
    unique case (sel)
      2'd0:    r = 3'd1;
      2'd1:    r = 3'd2;
      2'd2:    r = 3'd4;
      default: r = 3'd6;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/pulse_channel_length_envelope.sv]
// Square-wave sound channel with length counter and volume envelope.
// Input channel (in_valid/in_ready) carries one item: a register write, a
// tick of machine cycles, or a sample request, chosen by mode. Each item
// gives exactly one result on the output channel (out_valid/out_ready):
// read_back, sample_out, channel_on and volume_now.
// The cfg channel (cfg_valid/cfg_ready/cfg_data) sets the host sample rate;
// it is always ready. The user must write it only while no item is in flight;
// the block itself does not enforce this. One item is worked on at a time.
// Writes, ticks and disabled sample requests pass the decode and finish
// states before the result and the next in_ready. An enabled sample request
// runs two divisions, tone and then step, on a shared restoring divider, one
// quotient bit per cycle, 17 + PHASE_FRAC_BITS bits each, before the result
// and the next in_ready.
// The result sits in an output register; in_ready returns while it waits.
// A stalled receiver holds the result; a following item finishes its work
// and then waits until the held result is transferred.
// Reset (synchronous, active high) restores the power-up channel state and
// the default sample rate of 44100 and drops any pending result.
`default_nettype none
module pulse_channel_length_envelope
  import pcle_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [RATE_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        mode,
  input  wire logic [2:0]        reg_select,
  input  wire logic [7:0]        write_data,
  input  wire logic [9:0]        tick_cycles,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [7:0]        read_back,
  output logic      [7:0]        sample_out,
  output logic                   channel_on,
  output logic      [3:0]        volume_now
);

  pcle_cmd_t    cmd;
  pcle_status_t status;

  assign cfg_ready = 1'b1;

  pcle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  pcle_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .mode        (mode),
    .reg_select  (reg_select),
    .write_data  (write_data),
    .tick_cycles (tick_cycles),
    .read_back   (read_back),
    .sample_out  (sample_out),
    .channel_on  (channel_on),
    .volume_now  (volume_now)
  );

endmodule
`default_nettype wire

[sv/pcle_div.sv]
`default_nettype none
module pcle_div
  import pcle_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quot,
  output logic                  done
);

  logic [NUM_W-1:0] qr;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, qr[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign quot  = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qr    <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, den_q});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      qr <= {qr[NUM_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

[sv/pcle_datapath.sv]
`default_nettype none
module pcle_datapath
  import pcle_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pcle_cmd_t         cmd,
  output pcle_status_t           status,
  input  wire logic              cfg_we,
  input  wire logic [RATE_W-1:0] cfg_data,
  input  wire logic [1:0]        mode,
  input  wire logic [2:0]        reg_select,
  input  wire logic [7:0]        write_data,
  input  wire logic [9:0]        tick_cycles,
  output logic      [7:0]        read_back,
  output logic      [7:0]        sample_out,
  output logic                   channel_on,
  output logic      [3:0]        volume_now
);

  localparam logic [PHASE_BITS-1:0] PHASE_ONE =
    {{(PHASE_BITS-PHASE_FRAC_BITS-1){1'b0}}, 1'b1, {PHASE_FRAC_BITS{1'b0}}};

  // latched item
  logic [1:0] it_mode;
  logic [2:0] it_sel;
  logic [7:0] it_data;
  logic [9:0] it_cycles;

  logic [RATE_W-1:0]     output_rate;
  logic [1:0]            duty_select;
  logic [20:0]           length_left;
  logic                  length_enable;
  logic [3:0]            volume_latch;
  logic [3:0]            env_volume;
  logic                  env_rising;
  logic [18:0]           env_reload;
  logic [18:0]           env_countdown;
  logic [10:0]           tone_freq;
  logic                  active_flag;
  logic                  master_enable;
  logic [PHASE_BITS-1:0] phase_count;
  logic [2:0]            duty_position;

  logic [1:0]            duty_select_next;
  logic [20:0]           length_left_next;
  logic                  length_enable_next;
  logic [3:0]            volume_latch_next;
  logic [3:0]            env_volume_next;
  logic                  env_rising_next;
  logic [18:0]           env_reload_next;
  logic [18:0]           env_countdown_next;
  logic [10:0]           tone_freq_next;
  logic                  active_flag_next;
  logic                  master_enable_next;
  logic [PHASE_BITS-1:0] phase_count_next;
  logic [2:0]            duty_position_next;
  logic [7:0]            rb_next;
  logic [7:0]            smp_next;

  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] quot;
  logic             div_done;
  logic [11:0]      freq_span;
  logic             sample_go;
  logic             active_len;

  assign sample_go = (it_mode == MODE_SAMPLE) && master_enable && active_flag;
  assign status    = '{sample_go: sample_go, div_done: div_done};
  assign freq_span = 12'(FREQ_SPAN) - {1'b0, tone_freq};

  always_comb begin
    unique case (cmd.div_sel)
      DIV_TONE: begin
        div_num = NUM_W'(TONE_NUM);
        div_den = {{(DEN_W-12){1'b0}}, freq_span};
      end
      default: begin
        div_num = {output_rate, {PHASE_FRAC_BITS{1'b0}}};
        div_den = {quot[TONE_W-1:0], 3'b000};
      end
    endcase
  end

  pcle_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (quot),
    .done  (div_done)
  );

  always_comb begin
    duty_select_next   = duty_select;
    length_left_next   = length_left;
    length_enable_next = length_enable;
    volume_latch_next  = volume_latch;
    env_volume_next    = env_volume;
    env_rising_next    = env_rising;
    env_reload_next    = env_reload;
    env_countdown_next = env_countdown;
    tone_freq_next     = tone_freq;
    active_flag_next   = active_flag;
    master_enable_next = master_enable;
    phase_count_next   = phase_count;
    duty_position_next = duty_position;
    rb_next            = 8'd0;
    smp_next           = 8'd0;
    active_len         = active_flag;

    unique case (it_mode)
      MODE_WRITE: begin
        unique case (it_sel)
          REG_LEN_DUTY: begin
            duty_select_next = it_data[7:6];
            length_left_next = {7'(LEN_FULL) - {1'b0, it_data[5:0]}, 14'd0};
            rb_next          = it_data;
          end
          REG_ENVELOPE: begin
            volume_latch_next  = it_data[7:4];
            env_volume_next    = it_data[7:4];
            env_rising_next    = it_data[3];
            env_reload_next    = {it_data[2:0], 16'd0};
            env_countdown_next = {it_data[2:0], 16'd0};
            rb_next            = it_data;
          end
          REG_FREQ_LO: begin
            tone_freq_next = {tone_freq[10:8], it_data};
            rb_next        = RB_FREQ_LO;
          end
          REG_FREQ_HI: begin
            tone_freq_next     = {it_data[2:0], tone_freq[7:0]};
            length_enable_next = it_data[6];
            if (it_data[7]) begin
              active_flag_next = 1'b1;
              if (length_left == '0) begin
                length_left_next = {7'(LEN_FULL), 14'd0};
              end
              env_volume_next    = volume_latch;
              env_countdown_next = env_reload;
            end
            rb_next = it_data | RB_TRIGGER;
          end
          REG_MASTER: begin
            master_enable_next = it_data[7];
            rb_next = {it_data[7], 3'b111, 2'b00, active_flag, 1'b0};
          end
          default: rb_next = RB_UNUSED;
        endcase
      end
      MODE_TICK: begin
        if (length_enable) begin
          if (length_left <= {11'd0, it_cycles}) begin
            length_left_next = '0;
            active_len       = 1'b0;
          end else begin
            length_left_next = length_left - {11'd0, it_cycles};
          end
        end
        active_flag_next = active_len;
        // envelope runs on the activity left after the length count
        if (env_countdown != '0 && active_len) begin
          if (env_countdown <= {9'd0, it_cycles}) begin
            if (env_rising) begin
              if (env_volume != 4'hF) env_volume_next = env_volume + 1'b1;
            end else begin
              if (env_volume != 4'h0) env_volume_next = env_volume - 1'b1;
            end
            env_countdown_next = env_reload;
          end else begin
            env_countdown_next = env_countdown - {9'd0, it_cycles};
          end
        end
      end
      MODE_SAMPLE: begin
        if (sample_go) begin
          if ({{(NUM_W-PHASE_BITS){1'b0}}, phase_count} <= quot) begin
            phase_count_next = phase_count + PHASE_ONE;
          end else begin
            duty_position_next = duty_position + 1'b1;
            phase_count_next   = phase_count - quot[PHASE_BITS-1:0] + PHASE_ONE;
          end
          if (duty_position_next >= duty_first_high(duty_select)) begin
            smp_next = {env_volume, env_volume};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      it_mode   <= mode;
      it_sel    <= reg_select;
      it_data   <= write_data;
      it_cycles <= tick_cycles;
    end
    if (cmd.commit) begin
      read_back  <= rb_next;
      sample_out <= smp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_rate   <= RATE_RESET;
      duty_select   <= 2'd2;
      length_left   <= '0;
      length_enable <= 1'b0;
      volume_latch  <= '0;
      env_volume    <= '0;
      env_rising    <= 1'b0;
      env_reload    <= '0;
      env_countdown <= '0;
      tone_freq     <= '0;
      active_flag   <= 1'b0;
      master_enable <= 1'b1;
      phase_count   <= '0;
      duty_position <= '0;
    end else begin
      if (cfg_we) begin
        output_rate <= cfg_data;
      end
      if (cmd.commit) begin
        duty_select   <= duty_select_next;
        length_left   <= length_left_next;
        length_enable <= length_enable_next;
        volume_latch  <= volume_latch_next;
        env_volume    <= env_volume_next;
        env_rising    <= env_rising_next;
        env_reload    <= env_reload_next;
        env_countdown <= env_countdown_next;
        tone_freq     <= tone_freq_next;
        active_flag   <= active_flag_next;
        master_enable <= master_enable_next;
        phase_count   <= phase_count_next;
        duty_position <= duty_position_next;
      end
    end
  end

  // state changes only together with an output load, so these track the held result
  assign channel_on = active_flag;
  assign volume_now = env_volume;

endmodule
`default_nettype wire

[sv/pcle_ctrl.sv]
`default_nettype none
module pcle_ctrl
  import pcle_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output pcle_cmd_t         cmd,
  input  wire pcle_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV_TONE,
    S_DIV_STEP,
    S_FINISH
  } state_t;

  state_t state;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd = '{latch: 1'b0, div_start: 1'b0, div_sel: DIV_TONE, commit: 1'b0};
    unique case (state)
      S_IDLE:     cmd.latch = in_valid;
      S_DECODE:   cmd.div_start = status.sample_go;
      S_DIV_TONE: begin
        cmd.div_sel   = DIV_STEP;
        cmd.div_start = status.div_done;
      end
      S_DIV_STEP: ;
      S_FINISH:   cmd.commit = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DECODE;
        end
        S_DECODE: begin
          state <= status.sample_go ? S_DIV_TONE : S_FINISH;
        end
        S_DIV_TONE: begin
          if (status.div_done) state <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          if (status.div_done) state <= S_FINISH;
        end
        S_FINISH: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/pcle_checker.sv]
`default_nettype none
module pcle_checker
  import pcle_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] read_back,
  input wire logic [7:0] sample_out,
  input wire logic       channel_on
);

  // one item in flight: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_back) && $stable(sample_out))
    else $error("stalled result changed");

  // a result is either a write read-back or a sample, never both
  a_rb_or_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (read_back == 8'd0 || sample_out == 8'd0))
    else $error("read_back and sample_out both nonzero");

  a_sample_needs_on: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_out != 8'd0 |-> channel_on)
    else $error("sample output while channel off");

endmodule

bind pulse_channel_length_envelope pcle_checker u_pcle_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .read_back  (read_back),
  .sample_out (sample_out),
  .channel_on (channel_on)
);
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
  import pcle_pkg::*;

  localparam int          ITEMS_TARGET   = 1450;
  localparam int          RANDOM_PHASES  = 7;
  // bursts overrun the quota by about 40 items on average
  localparam int          PHASE_QUOTA    = (ITEMS_TARGET - 50) / RANDOM_PHASES - 40;
  localparam int          DRAIN_CYCLES   = 2 * (RATE_W + PHASE_FRAC_BITS) + 20;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          IDLE_PCT       = 32;
  localparam logic [1:0]  MODE_NONE      = 2'd3;
  localparam logic [2:0]  REG_SPARE_LO   = 3'd5;
  localparam logic [2:0]  REG_SPARE_HI   = 3'd7;
  localparam longint unsigned PHASE_UNIT = 64'd1 << PHASE_FRAC_BITS;

  typedef struct packed {
    logic [7:0] read_back;
    logic [7:0] sample_out;
    logic       channel_on;
    logic [3:0] volume_now;
  } chan_result_t;

  logic              clk;
  logic              rst         = 1'b1;
  logic              cfg_valid   = 1'b0;
  logic              cfg_ready;
  logic [RATE_W-1:0] cfg_data    = '0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [1:0]        mode        = MODE_WRITE;
  logic [2:0]        reg_select  = REG_LEN_DUTY;
  logic [7:0]        write_data  = '0;
  logic [9:0]        tick_cycles = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [7:0]        read_back;
  logic [7:0]        sample_out;
  logic              channel_on;
  logic [3:0]        volume_now;

  // channel state as the checker sees it
  logic [RATE_W-1:0]     ch_rate;
  logic [1:0]            ch_duty;
  logic [20:0]           ch_length;
  logic                  ch_len_en;
  logic [3:0]            ch_vol_latch;
  logic [3:0]            ch_vol;
  logic                  ch_env_up;
  logic [18:0]           ch_env_reload;
  logic [19:0]           ch_env_count;
  logic [10:0]           ch_freq;
  logic                  ch_active;
  logic                  ch_master;
  logic [PHASE_BITS-1:0] ch_phase;
  logic [2:0]            ch_duty_pos;
  logic [2:0]            first_high_step [4] = '{3'd1, 3'd2, 3'd4, 3'd6};

  chan_result_t pending_results [$];
  int           mismatches   = 0;
  int           items_sent   = 0;
  int           stall_cycles = 0;
  bit           idle_on      = 1'b1;
  bit           hold_req     = 1'b0;

  pulse_channel_length_envelope i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .reg_select  (reg_select),
    .write_data  (write_data),
    .tick_cycles (tick_cycles),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_back   (read_back),
    .sample_out  (sample_out),
    .channel_on  (channel_on),
    .volume_now  (volume_now)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic reset_channel_state();
    ch_rate       = RATE_RESET;
    ch_duty       = 2'd2;
    ch_length     = '0;
    ch_len_en     = 1'b0;
    ch_vol_latch  = '0;
    ch_vol        = '0;
    ch_env_up     = 1'b0;
    ch_env_reload = '0;
    ch_env_count  = '0;
    ch_freq       = '0;
    ch_active     = 1'b0;
    ch_master     = 1'b1;
    ch_phase      = '0;
    ch_duty_pos   = '0;
  endtask

  // applies one item to the channel state and returns the result it gives
  task automatic advance_channel(input logic [1:0] md, input logic [2:0] sel,
                                 input logic [7:0] d, input logic [9:0] cyc,
                                 output chan_result_t r);
    longint unsigned tone;
    longint unsigned phase_step;
    r = '0;
    case (md)
      MODE_WRITE: begin
        case (sel)
          REG_LEN_DUTY: begin
            ch_duty     = d[7:6];
            ch_length   = 21'((LEN_FULL - d[5:0]) << 14);
            r.read_back = d;
          end
          REG_ENVELOPE: begin
            ch_vol_latch  = d[7:4];
            ch_vol        = d[7:4];
            ch_env_up     = d[3];
            ch_env_reload = {d[2:0], 16'h0000};
            ch_env_count  = {1'b0, d[2:0], 16'h0000};
            r.read_back   = d;
          end
          REG_FREQ_LO: begin
            ch_freq[7:0] = d;
            r.read_back  = RB_FREQ_LO;
          end
          REG_FREQ_HI: begin
            ch_freq[10:8] = d[2:0];
            ch_len_en     = d[6];
            if (d[7]) begin
              ch_active = 1'b1;
              if (ch_length == 0) ch_length = 21'(LEN_FULL << 14);
              ch_vol       = ch_vol_latch;
              ch_env_count = {1'b0, ch_env_reload};
            end
            r.read_back = d | RB_TRIGGER;
          end
          REG_MASTER: begin
            ch_master = d[7];
            // status: master bit, three fixed ones, channel-on in bit 1
            r.read_back = {ch_master, 3'b111, 2'b00, ch_active, 1'b0};
          end
          default: r.read_back = RB_UNUSED;
        endcase
      end
      MODE_TICK: begin
        if (ch_len_en) begin
          if (ch_length <= cyc) begin
            ch_length = '0;
            ch_active = 1'b0;
          end else begin
            ch_length = ch_length - {11'd0, cyc};
          end
        end
        if (ch_env_count != 0 && ch_active) begin
          if (ch_env_count <= cyc) begin
            if (ch_env_up) begin
              if (ch_vol < 4'd15) ch_vol = ch_vol + 4'd1;
            end else if (ch_vol > 4'd0) begin
              ch_vol = ch_vol - 4'd1;
            end
            ch_env_count = {1'b0, ch_env_reload};
          end else begin
            ch_env_count = ch_env_count - {10'd0, cyc};
          end
        end
      end
      MODE_SAMPLE: begin
        if (ch_master && ch_active) begin
          tone       = longint'(TONE_NUM) / (longint'(FREQ_SPAN) - longint'(ch_freq));
          phase_step = (longint'(ch_rate) << PHASE_FRAC_BITS) / (tone * 64'd8);
          if (longint'(ch_phase) <= phase_step) begin
            ch_phase = PHASE_BITS'(ch_phase + PHASE_UNIT);
          end else begin
            ch_duty_pos = ch_duty_pos + 3'd1;
            ch_phase    = PHASE_BITS'(longint'(ch_phase) - phase_step + PHASE_UNIT);
          end
          if (ch_duty_pos >= first_high_step[ch_duty]) r.sample_out = 8'(17 * ch_vol);
        end
      end
      default: ;
    endcase
    r.channel_on = ch_active;
    r.volume_now = ch_vol;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 100) $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : predict_inputs
    chan_result_t r;
    if (!rst && in_valid && in_ready) begin
      advance_channel(mode, reg_select, write_data, tick_cycles, r);
      pending_results.push_back(r);
    end
  end

  always @(posedge clk) begin : check_results
    chan_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (read_back !== want.read_back)
          report_mismatch("read_back", read_back, want.read_back);
        if (sample_out !== want.sample_out)
          report_mismatch("sample_out", sample_out, want.sample_out);
        if (channel_on !== want.channel_on)
          report_mismatch("channel_on", channel_on, want.channel_on);
        if (volume_now !== want.volume_now)
          report_mismatch("volume_now", volume_now, want.volume_now);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side; a hold request parks out_ready low for a long stretch
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_item(input logic [1:0] md, input logic [2:0] sel,
                           input logic [7:0] d, input logic [9:0] cyc);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= md;
    reg_select  <= sel;
    write_data  <= d;
    tick_cycles <= cyc;
    do @(posedge clk); while (!in_ready);
    if (md != MODE_NONE) items_sent++;
  endtask

  task automatic do_write(input logic [2:0] sel, input logic [7:0] d);
    send_item(MODE_WRITE, sel, d, 10'($urandom_range(0, 1023)));
  endtask

  task automatic do_tick(input logic [9:0] cyc);
    send_item(MODE_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), cyc);
  endtask

  task automatic do_sample();
    send_item(MODE_SAMPLE, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
              10'($urandom_range(0, 1023)));
  endtask

  // drop valid, drain every pending result, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_rate(input logic [RATE_W-1:0] rate);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= rate;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ch_rate = rate;
  endtask

  task automatic test_power_up();
    do_sample();
    do_tick(10'd0);
    do_write(REG_MASTER, 8'h80);
    send_item(MODE_NONE, REG_LEN_DUTY, 8'hFF, 10'h3FF);
  endtask

  task automatic test_register_writes();
    do_write(REG_LEN_DUTY, 8'h00);
    do_write(REG_LEN_DUTY, 8'hFF);
    do_write(REG_ENVELOPE, 8'hF8);
    do_write(REG_ENVELOPE, 8'h00);
    do_write(REG_FREQ_LO, 8'h00);
    do_write(REG_FREQ_LO, 8'hFF);
    do_write(REG_FREQ_HI, 8'h3F);
    do_write(REG_SPARE_LO, 8'h00);
    do_write(REG_SPARE_HI, 8'hFF);
    do_write(REG_MASTER, 8'h7F);
    do_write(REG_MASTER, 8'hFF);
  endtask

  task automatic test_length_envelope();
    do_write(REG_LEN_DUTY, 8'hFF);
    do_write(REG_ENVELOPE, 8'hF1);
    do_write(REG_FREQ_HI, 8'hC7);
    repeat (3) do_sample();
    do_tick(10'h3FF);
    do_tick(10'd0);
  endtask

  // receiver stalls long while items keep coming, so the input backs up
  task automatic test_backpressure();
    wait_idle();
    hold_req = 1'b1;
    do_write(REG_FREQ_HI, 8'h87);
    repeat (5) do_sample();
    repeat (4) do_tick(10'($urandom_range(0, 1023)));
    wait_idle();
  endtask

  task automatic random_burst();
    int          kind;
    int          n;
    int          op;
    int          pick;
    bit          env_heavy;
    logic [7:0]  d;
    logic [3:0]  vol;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      // unstructured noise
      n = $urandom_range(5, 15);
      repeat (n) send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                           8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
    end else begin
      env_heavy = (kind < 30);
      d    = 8'($urandom_range(0, 255));
      d[7] = ($urandom_range(0, 9) != 0);
      do_write(REG_MASTER, d);
      if (env_heavy) begin
        // start near the saturation points so the clamp gets exercised
        pick = $urandom_range(0, 3);
        vol  = (pick < 2) ? 4'(pick) : 4'(12 + pick);
        do_write(REG_ENVELOPE, {vol, 1'($urandom_range(0, 1)), 3'($urandom_range(1, 2))});
      end else begin
        do_write(REG_ENVELOPE, 8'($urandom_range(0, 255)));
      end
      d = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1)) d[5:0] = 6'($urandom_range(58, 63));
      do_write(REG_LEN_DUTY, d);
      do_write(REG_FREQ_LO, 8'($urandom_range(0, 255)));
      d    = 8'($urandom_range(0, 255));
      d[7] = 1'b1;
      if (env_heavy) d[6] = 1'b0;
      do_write(REG_FREQ_HI, d);
      n = env_heavy ? $urandom_range(100, 160) : $urandom_range(8, 40);
      repeat (n) begin
        op = $urandom_range(0, 99);
        if (op < (env_heavy ? 85 : 40)) begin
          if (env_heavy || $urandom_range(0, 9) < 7)
            do_tick(10'($urandom_range(768, 1023)));
          else
            do_tick(10'($urandom_range(0, 1023)));
        end else if (op < 90) begin
          do_sample();
        end else if (op < 97) begin
          do_write(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        end else begin
          send_item(MODE_NONE, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    10'($urandom_range(0, 1023)));
        end
      end
    end
  endtask

  task automatic test_random();
    int          ph;
    int          start;
    logic [RATE_W-1:0] rate;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       rate = 17'd96000;
        1:       rate = 17'd8000;
        2:       rate = '0;
        3:       rate = '1;
        4:       rate = RATE_RESET;
        default: rate = 17'($urandom_range(8000, 96000));
      endcase
      set_rate(rate);
      // phase 1 runs with no idling on either side
      idle_on = (ph != 1);
      start   = items_sent;
      while (items_sent - start < PHASE_QUOTA) random_burst();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    reset_channel_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_power_up();
    test_register_writes();
    test_length_envelope();
    test_backpressure();
    test_random();
    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
sv/pcle_pkg.sv
sv/pcle_div.sv
sv/pcle_datapath.sv
sv/pcle_ctrl.sv
sv/pulse_channel_length_envelope.sv
sv/pcle_checker.sv
tb/tb_top.sv
